[rtl/obb_pkg.sv]
// Shared types, constants and helpers for the orthonormal basis builder.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package obb_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Three components, index 0 is x, 1 is y, 2 is z.
    typedef logic [2:0][DATA_W-1:0] vec3_t;

    // Absolute value of a signed component as an unsigned magnitude.
    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] neg;
        neg = DATA_W'(-v);
        return v[DATA_W-1] ? neg : v;
    endfunction

endpackage

[rtl/obb_in_if.sv]
// Input channel: one pair of vectors a and b per transfer.
// Uses obb_pkg for the component width.
`timescale 1ns / 1ps

interface obb_in_if;
    logic                        valid;
    logic                        ready;
    logic [obb_pkg::DATA_W-1:0]  a_x;
    logic [obb_pkg::DATA_W-1:0]  a_y;
    logic [obb_pkg::DATA_W-1:0]  a_z;
    logic [obb_pkg::DATA_W-1:0]  b_x;
    logic [obb_pkg::DATA_W-1:0]  b_y;
    logic [obb_pkg::DATA_W-1:0]  b_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
    modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

[rtl/obb_out_if.sv]
// Output channel: one orthonormal basis and degenerate flag per transfer.
// Uses obb_pkg for the component width.
`timescale 1ns / 1ps

interface obb_out_if;
    logic                        valid;
    logic                        ready;
    logic [obb_pkg::DATA_W-1:0]  unit_a_x;
    logic [obb_pkg::DATA_W-1:0]  unit_a_y;
    logic [obb_pkg::DATA_W-1:0]  unit_a_z;
    logic [obb_pkg::DATA_W-1:0]  new_b_x;
    logic [obb_pkg::DATA_W-1:0]  new_b_y;
    logic [obb_pkg::DATA_W-1:0]  new_b_z;
    logic [obb_pkg::DATA_W-1:0]  c_x;
    logic [obb_pkg::DATA_W-1:0]  c_y;
    logic [obb_pkg::DATA_W-1:0]  c_z;
    logic                        degenerate;

    modport source (output valid, unit_a_x, unit_a_y, unit_a_z, new_b_x, new_b_y, new_b_z,
                    c_x, c_y, c_z, degenerate, input ready);
    modport sink   (input valid, unit_a_x, unit_a_y, unit_a_z, new_b_x, new_b_y, new_b_z,
                    c_x, c_y, c_z, degenerate, output ready);
endinterface

[rtl/obb_norm.sv]
// Pipelined vector normalizer: squares, sum, one root bit per stage,
// then three restoring dividers with one quotient bit per stage. Uses obb_pkg.
`timescale 1ns / 1ps

module obb_norm #(
    parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  obb_pkg::vec3_t      in_vec,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output obb_pkg::vec3_t      out_vec,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int DW        = obb_pkg::DATA_W;
    localparam int SUM_W     = 2 * DW;
    localparam int SQ_STEPS  = DW;
    localparam int REM_W     = DW + 2;
    localparam int DIV_STEPS = FRAC_BITS + 1;
    localparam int Q_W       = FRAC_BITS + 1;

    typedef struct packed {
        obb_pkg::vec3_t     vec;
        logic [SIDE_W-1:0]  side;
    } carry_t;

    // Squares
    logic [2:0][SUM_W-1:0] sq_reg;
    carry_t                s1_reg;
    logic                  s1_valid_reg;

    // Square root stages, index 0 holds the sum
    logic [SUM_W-1:0] rad_reg   [0:SQ_STEPS];
    logic [REM_W-1:0] srem_reg  [0:SQ_STEPS];
    logic [DW-1:0]    root_reg  [0:SQ_STEPS];
    carry_t           sc_reg    [0:SQ_STEPS];
    logic             sv_reg    [0:SQ_STEPS];

    // Divider stages, index 0 holds the setup
    logic [2:0][DW-1:0]  drem_reg [0:DIV_STEPS];
    logic [2:0]          lsb_reg  [0:DIV_STEPS];
    logic [2:0][Q_W-1:0] q_reg    [0:DIV_STEPS];
    logic [DW-1:0]       dm_reg   [0:DIV_STEPS];
    carry_t              dc_reg   [0:DIV_STEPS];
    logic                dv_reg   [0:DIV_STEPS];

    logic [2:0][DW-1:0]  dmag;

    logic                out_valid_reg;
    obb_pkg::vec3_t      out_vec_reg;
    logic [SIDE_W-1:0]   out_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sv_reg[0]    <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            sv_reg[0]    <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SUM_W'(obb_pkg::mag32(in_vec[i])) *
                             SUM_W'(obb_pkg::mag32(in_vec[i]));
            end
            s1_reg.vec  <= in_vec;
            s1_reg.side <= in_side;
            rad_reg[0]  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            srem_reg[0] <= '0;
            root_reg[0] <= '0;
            sc_reg[0]   <= s1_reg;
        end
    end

    for (genvar k = 1; k <= SQ_STEPS; k++)
    begin : g_sqrt
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             ge;

        always_comb
        begin
            rem_sh = {srem_reg[k-1], rad_reg[k-1][SUM_W-1:SUM_W-2]};
            trial  = (REM_W+2)'({root_reg[k-1], 2'b01});
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= {rad_reg[k-1][SUM_W-3:0], 2'b00};
                srem_reg[k] <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_reg[k] <= {root_reg[k-1][DW-2:0], ge};
                sc_reg[k]   <= sc_reg[k-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dmag[i] = obb_pkg::mag32(sc_reg[SQ_STEPS].vec[i]);
        end
    end

    // Divider setup: remainder starts at |v| >> 1, the last dividend bit is |v|[0]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= sv_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[0][i] <= {1'b0, dmag[i][DW-1:1]};
                lsb_reg[0][i]  <= dmag[i][0];
            end
            q_reg[0]  <= '0;
            dm_reg[0] <= root_reg[SQ_STEPS];
            dc_reg[0] <= sc_reg[SQ_STEPS];
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_div
        logic [2:0][DW:0] rsh;
        logic [2:0]       ge;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                rsh[i] = {drem_reg[j-1][i], (j == 1) ? lsb_reg[j-1][i] : 1'b0};
                ge[i]  = (rsh[i] >= {1'b0, dm_reg[j-1]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                dv_reg[j] <= dv_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[j][i] <= ge[i] ? DW'(rsh[i] - {1'b0, dm_reg[j-1]}) : DW'(rsh[i]);
                    q_reg[j][i]    <= {q_reg[j-1][i][Q_W-2:0], ge[i]};
                end
                lsb_reg[j] <= lsb_reg[j-1];
                dm_reg[j]  <= dm_reg[j-1];
                dc_reg[j]  <= dc_reg[j-1];
            end
        end
    end

    // Reapply sign; a zero vector passes unchanged
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dm_reg[DIV_STEPS] == '0)
                begin
                    out_vec_reg[i] <= dc_reg[DIV_STEPS].vec[i];
                end
                else if (dc_reg[DIV_STEPS].vec[i][DW-1])
                begin
                    out_vec_reg[i] <= DW'(-DW'(q_reg[DIV_STEPS][i]));
                end
                else
                begin
                    out_vec_reg[i] <= DW'(q_reg[DIV_STEPS][i]);
                end
            end
            out_side_reg <= dc_reg[DIV_STEPS].side;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;
    assign out_side  = out_side_reg;

endmodule

[rtl/obb_cross.sv]
// Pipelined fixed-point cross product with truncating rescale and saturation.
// Three register stages: products, differences, rescale. Uses obb_pkg.
`timescale 1ns / 1ps

module obb_cross #(
    parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  obb_pkg::vec3_t      p,
    input  obb_pkg::vec3_t      q,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output obb_pkg::vec3_t      r,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int DW     = obb_pkg::DATA_W;
    localparam int PROD_W = 2 * DW;
    localparam int DIFF_W = PROD_W + 1;
    localparam logic signed [DIFF_W-1:0] SAT_MAX = DIFF_W'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [DIFF_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [DIFF_W-1:0] BIAS    = DIFF_W'((65'd1 << FRAC_BITS) - 65'd1);

    logic signed [PROD_W-1:0] prod_reg [0:5];
    logic signed [DIFF_W-1:0] diff_reg [0:2];
    logic [SIDE_W-1:0]        side1_reg;
    logic [SIDE_W-1:0]        side2_reg;
    logic [SIDE_W-1:0]        side3_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    obb_pkg::vec3_t           r_reg;

    logic signed [DIFF_W-1:0] scaled [0:2];
    obb_pkg::vec3_t           r_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // bias negative values so the arithmetic shift truncates toward zero
            scaled[i] = $signed(diff_reg[i] + (diff_reg[i][DIFF_W-1] ? BIAS : '0))
                        >>> FRAC_BITS;
            if (scaled[i] > SAT_MAX)
            begin
                r_next[i] = SAT_MAX[DW-1:0];
            end
            else if (scaled[i] < SAT_MIN)
            begin
                r_next[i] = SAT_MIN[DW-1:0];
            end
            else
            begin
                r_next[i] = scaled[i][DW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= $signed(p[1]) * $signed(q[2]);
            prod_reg[1] <= $signed(p[2]) * $signed(q[1]);
            prod_reg[2] <= $signed(p[2]) * $signed(q[0]);
            prod_reg[3] <= $signed(p[0]) * $signed(q[2]);
            prod_reg[4] <= $signed(p[0]) * $signed(q[1]);
            prod_reg[5] <= $signed(p[1]) * $signed(q[0]);
            side1_reg   <= in_side;
            for (int i = 0; i < 3; i++)
            begin
                diff_reg[i] <= DIFF_W'(prod_reg[2*i]) - DIFF_W'(prod_reg[2*i+1]);
            end
            side2_reg <= side1_reg;
            r_reg     <= r_next;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign r         = r_reg;
    assign out_side  = side3_reg;

endmodule

[rtl/orthonormal_basis_builder_core.sv]
// Orthonormal basis builder: one pipelined datapath from vector pair to basis.
// Depends on obb_pkg, obb_in_if, obb_out_if, obb_norm and obb_cross.
`timescale 1ns / 1ps

// Takes a pair of Q(31-FRAC_BITS).FRAC_BITS vectors a and b per transfer and
// returns unit a, c = unit a x b normalized, and new b = c x unit a, or the
// original b with c zero and degenerate set when the cross product truncates
// to zero. A new pair is accepted every cycle unless a result is held at the
// output. Stages in order: normalizer of a, cross product, normalizer of c,
// cross product, then one output register; each normalizer has a 32-stage
// square root and a FRAC_BITS + 1 stage divider. The whole pipeline holds
// while a result waits at the output.
module orthonormal_basis_builder_core #(
    parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    obb_in_if.sink     pairs,
    obb_out_if.source  basis
);

    typedef struct packed {
        obb_pkg::vec3_t ua;
        obb_pkg::vec3_t b;
    } side_x1_t;

    typedef struct packed {
        obb_pkg::vec3_t ua;
        obb_pkg::vec3_t b;
        logic           degen;
    } side_nc_t;

    typedef struct packed {
        obb_pkg::vec3_t ua;
        obb_pkg::vec3_t b;
        obb_pkg::vec3_t uc;
        logic           degen;
    } side_x2_t;

    logic           en;
    obb_pkg::vec3_t a_in;
    obb_pkg::vec3_t b_in;

    logic           na_valid;
    obb_pkg::vec3_t na_vec;
    obb_pkg::vec3_t na_side;

    logic           x1_valid;
    obb_pkg::vec3_t x1_c;
    side_x1_t       x1_in_side;
    side_x1_t       x1_side;

    side_nc_t       nc_in_side;
    logic           nc_valid;
    obb_pkg::vec3_t nc_vec;
    side_nc_t       nc_side;

    side_x2_t       x2_in_side;
    logic           x2_valid;
    obb_pkg::vec3_t x2_r;
    side_x2_t       x2_side;

    logic           out_valid_reg;
    obb_pkg::vec3_t ua_reg;
    obb_pkg::vec3_t nb_reg;
    obb_pkg::vec3_t c_reg;
    logic           degen_reg;

    // Advance every stage unless a result is held at the output
    assign en          = !out_valid_reg || basis.ready;
    assign pairs.ready = en;

    assign a_in = {pairs.a_z, pairs.a_y, pairs.a_x};
    assign b_in = {pairs.b_z, pairs.b_y, pairs.b_x};

    obb_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(obb_pkg::vec3_t))
    ) u_norm_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pairs.valid),
        .in_vec    (a_in),
        .in_side   (b_in),
        .out_valid (na_valid),
        .out_vec   (na_vec),
        .out_side  (na_side)
    );

    assign x1_in_side.ua = na_vec;
    assign x1_in_side.b  = na_side;

    obb_cross #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(side_x1_t))
    ) u_cross_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (na_valid),
        .p         (na_vec),
        .q         (na_side),
        .in_side   (x1_in_side),
        .out_valid (x1_valid),
        .r         (x1_c),
        .out_side  (x1_side)
    );

    assign nc_in_side.ua    = x1_side.ua;
    assign nc_in_side.b     = x1_side.b;
    assign nc_in_side.degen = (x1_c == '0);

    obb_norm #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(side_nc_t))
    ) u_norm_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (x1_valid),
        .in_vec    (x1_c),
        .in_side   (nc_in_side),
        .out_valid (nc_valid),
        .out_vec   (nc_vec),
        .out_side  (nc_side)
    );

    assign x2_in_side.ua    = nc_side.ua;
    assign x2_in_side.b     = nc_side.b;
    assign x2_in_side.uc    = nc_vec;
    assign x2_in_side.degen = nc_side.degen;

    obb_cross #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(side_x2_t))
    ) u_cross_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nc_valid),
        .p         (nc_vec),
        .q         (nc_side.ua),
        .in_side   (x2_in_side),
        .out_valid (x2_valid),
        .r         (x2_r),
        .out_side  (x2_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= x2_valid;
        end
    end

    // Degenerate pairs keep the original b
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg    <= x2_side.ua;
            nb_reg    <= x2_side.degen ? x2_side.b : x2_r;
            c_reg     <= x2_side.uc;
            degen_reg <= x2_side.degen;
        end
    end

    assign basis.valid      = out_valid_reg;
    assign basis.unit_a_x   = ua_reg[0];
    assign basis.unit_a_y   = ua_reg[1];
    assign basis.unit_a_z   = ua_reg[2];
    assign basis.new_b_x    = nb_reg[0];
    assign basis.new_b_y    = nb_reg[1];
    assign basis.new_b_z    = nb_reg[2];
    assign basis.c_x        = c_reg[0];
    assign basis.c_y        = c_reg[1];
    assign basis.c_z        = c_reg[2];
    assign basis.degenerate = degen_reg;

endmodule
